// ===== rtl/assert_macros.svh =====
// Assertion helpers for the allocator RTL.
// Each macro expects the signals clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared codes and widths of the first-fit page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

  localparam int REQ_W   = 13;
  localparam int OFFS_W  = 12;
  localparam int STAT_W  = 2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [7:0] {
    S_INIT     = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_CHECK    = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_MOVE     = 8'b0001_0000,
    S_SPLIT_LO = 8'b0010_0000,
    S_SPLIT_HI = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit allocator over one page with an address-ordered segment list.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready (action, request_bytes,
//   buffer_offset); one result per request leaves on out_valid/out_ready
//   (status, granted_offset). One request at a time; in_ready stays low
//   until it is finished.
//   Allocate: accept, size check, the segment scan (one entry per cycle),
//   for a split the move of the entries above the hit and the two split
//   writes, and the result.
//   Free: accept, scan, result. The worst case is set by the scan and the
//   entry move, which share the one memory read port.
//   After reset the init state writes the whole-page segment into entry 0
//   before in_ready rises. A stalled receiver holds the result in the output
//   register; the next request is still taken, and its result waits in the
//   final state until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module first_fit_page_allocator #(
  parameter int PAGE_BYTES   = 4096,
  parameter int UNIT_BYTES   = 8,
  parameter int MAX_SEGMENTS = 512
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            action,
  input  wire  [ffpa_pkg::REQ_W-1:0]     request_bytes,
  input  wire  [ffpa_pkg::OFFS_W-1:0]    buffer_offset,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [ffpa_pkg::STAT_W-1:0]    status,
  output logic [ffpa_pkg::OFFS_W-1:0]    granted_offset
);
  import ffpa_pkg::*;

  function automatic int trailing_zeros(input int value);
    int n;
    n = 0;
    while ((n < 30) && (((value >> n) & 1) == 0)) begin
      n = n + 1;
    end
    return n;
  endfunction

  // Inverse of an odd value modulo 2^width by Newton iteration.
  function automatic int odd_inverse(input int odd_val, input int width);
    int mask;
    int inv;
    int k;
    mask = (1 << width) - 1;
    inv  = odd_val & mask;
    for (k = 0; k < 5; k++) begin
      inv = (inv * ((2 - ((odd_val * inv) & mask)) & mask)) & mask;
    end
    return inv;
  endfunction

  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int SIZE_W = $clog2(PAGE_BYTES + 1);
  localparam int ENT_W  = OFF_W + SIZE_W + 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  localparam int               UNIT_SH   = trailing_zeros(UNIT_BYTES);
  localparam int               UNIT_ODD  = UNIT_BYTES >> UNIT_SH;
  localparam logic [REQ_W-1:0] UNIT_INV  = REQ_W'(odd_inverse(UNIT_ODD, REQ_W));
  localparam logic [REQ_W-1:0] DIV_LIMIT = REQ_W'(((1 << REQ_W) - 1) / UNIT_ODD);
  localparam logic [REQ_W-1:0] LOW_MASK  = REQ_W'((1 << UNIT_SH) - 1);

  // Segment memory, entry = {free, size, offset}.
  logic [ENT_W-1:0] mem [MAX_SEGMENTS];

  state_t             state, state_next;
  logic [CNT_W-1:0]   seg_count, seg_count_next;
  logic               is_free_op;
  logic [REQ_W-1:0]   req_q;
  logic [OFFS_W-1:0]  off_q;
  logic [CNT_W-1:0]   issue_idx, issue_idx_next;
  logic [CNT_W-1:0]   mv_idx, mv_idx_next;
  logic [CNT_W-1:0]   hit_idx, hit_idx_next;
  logic [OFF_W-1:0]   hit_off, hit_off_next;
  logic [SIZE_W-1:0]  hit_size, hit_size_next;
  logic [STAT_W-1:0]  res_status, res_status_next;
  logic [OFF_W-1:0]   res_granted, res_granted_next;

  logic               rd_en, rd_valid, wr_en;
  logic [CNT_W-1:0]   rd_addr, rd_idx, wr_addr;
  logic [ENT_W-1:0]   rd_data, wr_data;

  logic [OFF_W-1:0]   rd_off;
  logic [SIZE_W-1:0]  rd_size;
  logic               rd_free;
  logic [SIZE_W-1:0]  req_sz;
  logic               can_split, alloc_fit, exact, take, more, bad_range;
  logic [REQ_W-1:0]   req_hi, req_prod;
  logic               unit_ok;
  logic               load_out, in_xfer;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign rd_off  = rd_data[OFF_W-1:0];
  assign rd_size = rd_data[OFF_W+SIZE_W-1:OFF_W];
  assign rd_free = rd_data[ENT_W-1];
  assign req_sz  = SIZE_W'(req_q);

  assign can_split = seg_count < CNT_W'(MAX_SEGMENTS);
  assign exact     = (rd_size == req_sz);
  assign alloc_fit = rd_valid && rd_free && (rd_size >= req_sz);
  assign take      = is_free_op ? (rd_valid && (32'(rd_off) == 32'(off_q)))
                                : (alloc_fit && (exact || can_split));
  assign more      = issue_idx < seg_count;
  assign bad_range = (req_q == '0) || (32'(req_q) > 32'(PAGE_BYTES));

  // The unit splits into a power of two and an odd part. The low bits must be
  // zero, and the rest is a multiple of the odd part exactly when its product
  // with the inverse of that part, modulo 2^REQ_W, stays at or below the limit.
  assign req_hi   = req_q >> UNIT_SH;
  assign req_prod = REQ_W'(req_hi * UNIT_INV);
  assign unit_ok  = ((req_q & LOW_MASK) == '0) && (req_prod <= DIV_LIMIT);

  always_comb begin
    state_next       = state;
    seg_count_next   = seg_count;
    issue_idx_next   = issue_idx;
    mv_idx_next      = mv_idx;
    hit_idx_next     = hit_idx;
    hit_off_next     = hit_off;
    hit_size_next    = hit_size;
    res_status_next  = res_status;
    res_granted_next = res_granted;
    rd_en            = 1'b0;
    rd_addr          = issue_idx;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;
    load_out         = 1'b0;
    unique case (state)
      S_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = {1'b1, SIZE_W'(PAGE_BYTES), OFF_W'(0)};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          issue_idx_next = '0;
          state_next     = (action == ACT_FREE) ? S_SCAN : S_CHECK;
        end
      end
      S_CHECK: begin
        if (bad_range || !unit_ok) begin
          res_status_next  = ST_BAD_SIZE;
          res_granted_next = '0;
          state_next       = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (take) begin
          if (is_free_op || exact) begin
            wr_en            = 1'b1;
            wr_addr          = rd_idx;
            wr_data          = {is_free_op, rd_size, rd_off};
            res_status_next  = ST_OK;
            res_granted_next = is_free_op ? '0 : rd_off;
            state_next       = S_FINISH;
          end else begin
            hit_idx_next  = rd_idx;
            hit_off_next  = rd_off;
            hit_size_next = rd_size;
            mv_idx_next   = seg_count - CNT_W'(1);
            state_next    = S_MOVE;
          end
        end else if (more) begin
          rd_en          = 1'b1;
          rd_addr        = issue_idx;
          issue_idx_next = issue_idx + CNT_W'(1);
        end else if (!rd_valid) begin
          res_status_next  = is_free_op ? ST_NOT_FOUND : ST_NO_FIT;
          res_granted_next = '0;
          state_next       = S_FINISH;
        end
      end
      S_MOVE: begin
        // Entries above the hit move up by one, highest first; each read
        // is written back one place higher in the following cycle.
        if (mv_idx > hit_idx) begin
          rd_en       = 1'b1;
          rd_addr     = mv_idx;
          mv_idx_next = mv_idx - CNT_W'(1);
        end
        if (rd_valid) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx + CNT_W'(1);
          wr_data = rd_data;
        end
        if (!(mv_idx > hit_idx) && !rd_valid) begin
          state_next = S_SPLIT_LO;
        end
      end
      S_SPLIT_LO: begin
        wr_en      = 1'b1;
        wr_addr    = hit_idx;
        wr_data    = {1'b0, req_sz, hit_off};
        state_next = S_SPLIT_HI;
      end
      S_SPLIT_HI: begin
        wr_en            = 1'b1;
        wr_addr          = hit_idx + CNT_W'(1);
        wr_data          = {1'b1, SIZE_W'(hit_size - req_sz),
                            OFF_W'(SIZE_W'(hit_off) + req_sz)};
        seg_count_next   = seg_count + CNT_W'(1);
        res_status_next  = ST_OK;
        res_granted_next = hit_off;
        state_next       = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[IDX_W-1:0]];
      rd_idx  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      seg_count <= CNT_W'(1);
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      seg_count <= seg_count_next;
      rd_valid  <= rd_en;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      is_free_op <= action;
      req_q      <= request_bytes;
      off_q      <= buffer_offset;
    end
    issue_idx   <= issue_idx_next;
    mv_idx      <= mv_idx_next;
    hit_idx     <= hit_idx_next;
    hit_off     <= hit_off_next;
    hit_size    <= hit_size_next;
    res_status  <= res_status_next;
    res_granted <= res_granted_next;
    if (load_out) begin
      status         <= res_status;
      granted_offset <= OFFS_W'(res_granted);
    end
  end

  // The list never empties and never outgrows the memory.
  `CHK_SAME(a_count_range, 1'b1,
            (seg_count != '0) && (seg_count <= CNT_W'(MAX_SEGMENTS)))
  // A failed request never reports a granted offset.
  `CHK_SAME(a_fail_zero, out_valid && (status != ST_OK), granted_offset == '0)
  // Every move write lands inside the grown list.
  `CHK_SAME(a_move_bound, (state == S_MOVE) && rd_valid,
            (rd_idx > hit_idx) && (rd_idx < seg_count) && can_split)
  // A taken request keeps the input side closed in the next cycle.
  `CHK_NEXT(a_busy_after_xfer, in_xfer, !in_ready)

endmodule

`default_nettype wire
